@@ rtl/core/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants of the first-match route table
// Entry layout, lookup token that walks the cell chain, operation and status
// codes.
// ----------------------------------------------------------------------------
package frt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 32;
   localparam int FLAGS_W     = 8;
   localparam int METRIC_W    = 32;
   localparam int PORT_W      = 3;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED    = 3'd0,
      ST_FULL     = 3'd1,
      ST_MATCHED  = 3'd2,
      ST_FALLBACK = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_CLEARED  = 3'd5
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   dst;
      logic [ADDR_W-1:0]   mask;
      logic [ADDR_W-1:0]   gateway;
      logic [FLAGS_W-1:0]  flags;
      logic [METRIC_W-1:0] metric;
      logic [PORT_W-1:0]   port;
   } entry_type;

   // write request broadcast to every cell
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        ent;
   } entry_wr_type;

   // lookup in flight: address plus whatever entry has been picked so far
   typedef struct packed {
      logic              vld;
      logic              done;
      status_type        status;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] addr;
      entry_type         ent;
   } lookup_token_type;

endpackage

@@ rtl/core/first_match_route_table.sv @@
// ----------------------------------------------------------------------------
// first_match_route_table: bounded IPv4 route table, first-match lookup
// Add / lookup / clear over a chain of per-entry cells.
// ----------------------------------------------------------------------------
// One operation is in flight at a time: req_ready is low from the transfer of
// a request until its response transfers. Add, clear, a refused add (table
// full) and a lookup on an empty table answer on the cycle after the request
// transfer. A lookup walks the chain of TABLE_DEPTH cells, one cell per cycle,
// through each cell's token register and then the response register; the whole
// chain is walked whatever the fill count. The first entry in insertion order
// with (mask & address) == destination is returned; with no match the newest
// entry comes back with the fallback status. Operation code 3 is accepted and
// dropped with no response.
module first_match_route_table
   import frt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ADDR_W-1:0]   req_route_dst,
   input  logic [ADDR_W-1:0]   req_route_gateway,
   input  logic [ADDR_W-1:0]   req_route_mask,
   input  logic [FLAGS_W-1:0]  req_route_flags,
   input  logic [METRIC_W-1:0] req_route_metric,
   input  logic [PORT_W-1:0]   req_route_port,
   input  logic [ADDR_W-1:0]   req_lookup_addr,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_entry_index,
   output logic [ADDR_W-1:0]   rsp_hit_dst,
   output logic [ADDR_W-1:0]   rsp_hit_mask,
   output logic [ADDR_W-1:0]   rsp_hit_gateway,
   output logic [FLAGS_W-1:0]  rsp_hit_flags,
   output logic [METRIC_W-1:0] rsp_hit_metric,
   output logic [PORT_W-1:0]   rsp_hit_port
);

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   // response payload
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   entry_type        ent_ff, ent_in;

   logic             req_xfer;
   logic             rsp_xfer;
   logic             full;
   entry_type        req_ent;
   entry_wr_type     wr;
   lookup_token_type chain_tok [TABLE_DEPTH+1];

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign full      = count_ff >= CNT_W'(TABLE_DEPTH);

   assign req_ent.dst     = req_route_dst;
   assign req_ent.mask    = req_route_mask;
   assign req_ent.gateway = req_route_gateway;
   assign req_ent.flags   = req_route_flags;
   assign req_ent.metric  = req_route_metric;
   assign req_ent.port    = req_route_port;

   // appended entry goes to the cell at the current fill count
   assign wr.en  = req_xfer && req_func == FUNC_ADD && !full;
   assign wr.idx = count_ff[IDX_W-1:0];
   assign wr.ent = req_ent;

   // lookup token enters cell 0 on the request transfer
   always_comb begin
      chain_tok[0].vld    = req_xfer && req_func == FUNC_LOOKUP && count_ff != '0;
      chain_tok[0].done   = 1'b0;
      chain_tok[0].status = ST_MATCHED;
      chain_tok[0].idx    = '0;
      chain_tok[0].addr   = req_lookup_addr;
      chain_tok[0].ent    = '0;
   end

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      frt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_id     (IDX_W'(k)),
         .entry_count (count_ff),
         .wr          (wr),
         .tok_in      (chain_tok[k]),
         .tok_ff      (chain_tok[k+1])
      );
   end

   always_comb begin
      count_in     = count_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      ent_in       = ent_ff;

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end

      if (req_xfer) begin
         case (req_func)
            FUNC_ADD: begin
               busy_in      = 1'b1;
               rsp_valid_in = 1'b1;
               if (full) begin
                  status_in = ST_FULL;
                  idx_in    = '0;
                  ent_in    = '0;
               end else begin
                  status_in = ST_ADDED;
                  idx_in    = count_ff[IDX_W-1:0];
                  ent_in    = req_ent;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            FUNC_LOOKUP: begin
               busy_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_EMPTY;
                  idx_in       = '0;
                  ent_in       = '0;
               end
            end
            FUNC_CLEAR: begin
               busy_in      = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = ST_CLEARED;
               idx_in       = '0;
               ent_in       = '0;
               count_in     = '0;
            end
            default: begin
               // unused code: dropped, no response
            end
         endcase
      end

      // lookup leaves the end of the chain
      if (chain_tok[TABLE_DEPTH].vld) begin
         rsp_valid_in = 1'b1;
         status_in    = chain_tok[TABLE_DEPTH].status;
         idx_in       = chain_tok[TABLE_DEPTH].idx;
         ent_in       = chain_tok[TABLE_DEPTH].ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      idx_ff    <= idx_in;
      ent_ff    <= ent_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_index = idx_ff;
   assign rsp_hit_dst     = ent_ff.dst;
   assign rsp_hit_mask    = ent_ff.mask;
   assign rsp_hit_gateway = ent_ff.gateway;
   assign rsp_hit_flags   = ent_ff.flags;
   assign rsp_hit_metric  = ent_ff.metric;
   assign rsp_hit_port    = ent_ff.port;

endmodule

@@ rtl/core/frt_cell.sv @@
// ----------------------------------------------------------------------------
// frt_cell: one table entry plus one stage of the lookup chain
// Holds its entry, compares it against the passing lookup token and hands the
// token to the next cell through its token register.
// ----------------------------------------------------------------------------
module frt_cell
   import frt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_id,
   input  logic [CNT_W-1:0] entry_count,
   input  entry_wr_type     wr,
   input  lookup_token_type tok_in,
   output lookup_token_type tok_ff
);

   entry_type        entry_ff;
   lookup_token_type tok_in_next;
   logic             live;
   logic             last;
   logic             hit;

   assign live = {1'b0, cell_id} < entry_count;
   assign last = {1'b0, cell_id} == (entry_count - CNT_W'(1));
   assign hit  = (entry_ff.mask & tok_in.addr) == entry_ff.dst;

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.vld && !tok_in.done && live) begin
         if (hit) begin
            tok_in_next.done   = 1'b1;
            tok_in_next.status = ST_MATCHED;
            tok_in_next.idx    = cell_id;
            tok_in_next.ent    = entry_ff;
         end else if (last) begin
            // no match anywhere: last entry is the default route
            tok_in_next.done   = 1'b1;
            tok_in_next.status = ST_FALLBACK;
            tok_in_next.idx    = cell_id;
            tok_in_next.ent    = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == cell_id) begin
         entry_ff <= wr.ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff.vld <= tok_in_next.vld;
      end
      tok_ff.done   <= tok_in_next.done;
      tok_ff.status <= tok_in_next.status;
      tok_ff.idx    <= tok_in_next.idx;
      tok_ff.addr   <= tok_in_next.addr;
      tok_ff.ent    <= tok_in_next.ent;
   end

endmodule

@@ rtl/core/frt_checker.sv @@
// ----------------------------------------------------------------------------
// frt_checker: port-level checks for the route table
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module frt_checker
   import frt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [FUNC_W-1:0]   req_func,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [IDX_W-1:0]    rsp_entry_index,
   input logic [ADDR_W-1:0]   rsp_hit_dst
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_entry_index))
      else $error("response changed while stalled");

   // one transfer in flight: no request taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // clear answers on the next cycle
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_CLEAR |=>
         rsp_valid && rsp_status == ST_CLEARED)
      else $error("clear did not answer next cycle");

   // blank statuses carry a zero index and destination
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY ||
                    rsp_status == ST_CLEARED)
         |-> rsp_entry_index == '0 && rsp_hit_dst == '0)
      else $error("blank response with nonzero fields");

endmodule

bind first_match_route_table frt_checker u_frt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_entry_index (rsp_entry_index),
   .rsp_hit_dst     (rsp_hit_dst)
);
